[rtl/psk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_pkg - shared types and codes of the partitioned multi-stack
// Item layouts on the ports, the command word passed from front to back,
// operation and status codes, and the state type of the back end.
// ----------------------------------------------------------------------------
package psk_pkg;

    // Operation codes carried in func
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_SHOW = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Status codes carried in status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOSTACK = 2'd3;

    localparam int STACK_INDEX_W = 2;
    localparam int STACK_SLOTS   = 2 ** STACK_INDEX_W;
    localparam int COUNT_CFG_W   = 3;
    localparam int WORD_W        = 32;

    // Command fields sized for the largest supported memory (64 words)
    localparam int CMD_ADDR_W = 6;
    localparam int CMD_CNT_W  = 7;

    typedef struct packed {
        logic [1:0]               func;
        logic [STACK_INDEX_W-1:0] stack_index;
        logic signed [WORD_W-1:0] push_value;
    } req_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [1:0]               status;
        logic                     last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_READ,
        CMD_REPORT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [CMD_ADDR_W-1:0] addr;
        logic [CMD_CNT_W-1:0]  count;
        logic [WORD_W-1:0]     data;
        logic [1:0]            status;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

endpackage

[rtl/partitioned_multi_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partitioned_multi_stack - several stacks sharing one memory
// Splits a TOTAL_DEPTH-word memory into equal regions, one per stack, and
// carries out push, pop and display items on a chosen stack.
// ----------------------------------------------------------------------------
// Usage
//   Request: an item (func, stack_index, push_value) is taken at a clock
//   edge with start high and busy low. busy rises only while the two-entry
//   command queue between the front and back ends is full.
//   Results: each result is shown for exactly one cycle with done high;
//   there is no backpressure, so the receiver must take every result.
//   Configuration: cfg_we writes the stack count from cfg_data and clears
//   every stack; write it only while no item is in flight.
//   Path: an item passes the command queue, the memory access and the
//   result register before its first result appears.
//   Throughput: push, pop and error items do not hold the back end, so
//   one item per cycle is sustained while no display is being walked. A
//   display holds the back end for all its entries, one memory read and
//   one result per cycle, as the memory has a single read port.
//   Reset: one stack spanning the whole memory, all stacks empty, no clear
//   pass; memory contents are only read below a fill count.
// ----------------------------------------------------------------------------
module partitioned_multi_stack #(
    parameter int TOTAL_DEPTH = 32,
    parameter int MAX_STACKS  = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  psk_pkg::req_item_t              req,
    input  logic                            cfg_we,
    input  logic [psk_pkg::COUNT_CFG_W-1:0] cfg_data,
    output logic                            done,
    output psk_pkg::rsp_item_t              rsp
);

    import psk_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t q_cmd;
    cmd_t q_head;

    psk_front #(
        .TOTAL_DEPTH (TOTAL_DEPTH),
        .MAX_STACKS  (MAX_STACKS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    psk_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    psk_back #(
        .TOTAL_DEPTH (TOTAL_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .done    (done),
        .rsp     (rsp)
    );

    // The back end never takes a command from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("command taken from empty queue");

    // An error or empty report is always a lone result with a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.last && (rsp.value == '0)))
        else $error("error result not final or carries data");

    // A command pushed into a full queue would be lost
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_full && !q_pop) |=> (q_full || !$past(q_push)))
        else $error("queue lost a command");

endmodule

[rtl/psk_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/psk_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_front - accept and classify items
// Holds the stack count, region size and fill counts, checks each item against
// them, updates the fill count and queues at most one command for the back.
// ----------------------------------------------------------------------------
module psk_front #(
    parameter int TOTAL_DEPTH = 32,
    parameter int MAX_STACKS  = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  psk_pkg::req_item_t                   req,
    input  logic                                 cfg_we,
    input  logic [psk_pkg::COUNT_CFG_W-1:0]      cfg_data,
    input  logic                                 q_full,
    output logic                                 q_push,
    output psk_pkg::cmd_t                        q_cmd
);

    import psk_pkg::*;

    localparam int FW = $clog2(TOTAL_DEPTH + 1);
    localparam int AW = $clog2(TOTAL_DEPTH);
    localparam int PW = FW + STACK_INDEX_W;
    localparam logic [COUNT_CFG_W-1:0] N_CAP =
        (MAX_STACKS > 7) ? COUNT_CFG_W'(7) : COUNT_CFG_W'(MAX_STACKS);

    // Region size for each possible stack count
    function automatic logic [FW-1:0] region_of(input logic [COUNT_CFG_W-1:0] k);
        logic [FW-1:0] r;
        begin
            unique case (k)
                3'd2:    r = FW'(TOTAL_DEPTH / 2);
                3'd3:    r = FW'(TOTAL_DEPTH / 3);
                3'd4:    r = FW'(TOTAL_DEPTH / 4);
                3'd5:    r = FW'(TOTAL_DEPTH / 5);
                3'd6:    r = FW'(TOTAL_DEPTH / 6);
                3'd7:    r = FW'(TOTAL_DEPTH / 7);
                default: r = FW'(TOTAL_DEPTH);
            endcase
            region_of = r;
        end
    endfunction

    logic [COUNT_CFG_W-1:0] n_reg;
    logic [COUNT_CFG_W-1:0] n_next;
    logic [FW-1:0]          region_reg;
    logic [FW-1:0]          fill_reg [STACK_SLOTS];
    logic [FW-1:0]          fill_next;

    logic          accept;
    logic          stack_ok;
    logic [FW-1:0] fill;
    logic [PW-1:0] base_w;
    logic [PW-1:0] slot_w;
    logic [PW-1:0] top_w;
    logic          fill_we;

    assign busy   = q_full;
    assign accept = start && !busy;

    // Clamp the written stack count into the supported range
    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            n_next = COUNT_CFG_W'(1);
        end
        else if (cfg_data > N_CAP)
        begin
            n_next = N_CAP;
        end
        else
        begin
            n_next = cfg_data;
        end
    end

    // Locate the target stack's region and slots
    always_comb
    begin
        stack_ok = {1'b0, req.stack_index} < {1'b0, n_reg};
        fill     = fill_reg[req.stack_index];
        base_w   = PW'(req.stack_index) * PW'(region_reg);
        slot_w   = base_w + PW'(fill);
        top_w    = slot_w - PW'(1);
    end

    // Classify the item into one command
    always_comb
    begin
        q_push    = 1'b0;
        fill_we   = 1'b0;
        fill_next = fill;
        q_cmd     = '{kind: CMD_REPORT, addr: '0, count: '0, data: '0, status: ST_OK};
        q_cmd.data = req.push_value;
        if (accept)
        begin
            if (!stack_ok)
            begin
                q_push       = 1'b1;
                q_cmd.status = ST_NOSTACK;
            end
            else
            begin
                unique case (req.func)
                    FUNC_PUSH:
                    begin
                        q_push = 1'b1;
                        if (fill >= region_reg)
                        begin
                            q_cmd.status = ST_FULL;
                        end
                        else
                        begin
                            q_cmd.kind          = CMD_WRITE;
                            q_cmd.addr[AW-1:0]  = slot_w[AW-1:0];
                            fill_we             = 1'b1;
                            fill_next           = fill + FW'(1);
                        end
                    end
                    FUNC_POP:
                    begin
                        q_push = 1'b1;
                        if (fill == '0)
                        begin
                            q_cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            q_cmd.kind          = CMD_READ;
                            q_cmd.addr[AW-1:0]  = top_w[AW-1:0];
                            q_cmd.count         = CMD_CNT_W'(1);
                            fill_we             = 1'b1;
                            fill_next           = fill - FW'(1);
                        end
                    end
                    FUNC_SHOW:
                    begin
                        q_push = 1'b1;
                        if (fill == '0)
                        begin
                            q_cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            q_cmd.kind          = CMD_READ;
                            q_cmd.addr[AW-1:0]  = top_w[AW-1:0];
                            q_cmd.count         = CMD_CNT_W'(fill);
                        end
                    end
                    FUNC_NONE:
                    begin
                        // drop: unknown operation gives no result
                        q_push = 1'b0;
                    end
                    default:
                    begin
                        q_push = 1'b0;
                    end
                endcase
            end
        end
    end

    // Hold configuration; a write clears all fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= COUNT_CFG_W'(1);
            region_reg <= FW'(TOTAL_DEPTH);
            for (int i = 0; i < STACK_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            n_reg      <= n_next;
            region_reg <= region_of(n_next);
            for (int i = 0; i < STACK_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (fill_we)
        begin
            fill_reg[req.stack_index] <= fill_next;
        end
    end

endmodule

[rtl/psk_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_cmd_queue - two-entry command queue
// Decouples the front from the back so that each can stall on its own.
// ----------------------------------------------------------------------------
module psk_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  psk_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output psk_pkg::cmd_t head
);

    import psk_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full  = (count_reg == (PTR_W + 1)'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/psk_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psk_back - carry out queued commands against the stack memory
// Writes pushed words, reads popped words and walks a stack top to bottom
// for display, one memory access and at most one result per cycle.
// ----------------------------------------------------------------------------
module psk_back #(
    parameter int TOTAL_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  psk_pkg::cmd_t       q_head,
    output logic                q_pop,
    output logic                done,
    output psk_pkg::rsp_item_t  rsp
);

    import psk_pkg::*;

    localparam int FW = $clog2(TOTAL_DEPTH + 1);
    localparam int AW = $clog2(TOTAL_DEPTH);

    back_state_t state_reg;
    back_state_t state_next;
    logic [AW-1:0] walk_addr_reg;
    logic [AW-1:0] walk_addr_next;
    logic [FW-1:0] walk_left_reg;
    logic [FW-1:0] walk_left_next;

    // Issue-stage controls
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              issue;
    logic              issue_ram;
    logic [1:0]        issue_status;
    logic              issue_last;

    logic [AW-1:0] head_addr;
    logic [FW-1:0] head_count;

    // Result-stage registers
    logic       p_valid_reg;
    logic       p_use_ram_reg;
    logic [1:0] p_status_reg;
    logic       p_last_reg;
    logic       done_reg;
    rsp_item_t  rsp_reg;

    assign head_addr  = q_head.addr[AW-1:0];
    assign head_count = q_head.count[FW-1:0];

    psk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TOTAL_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_head.data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state and walk counters
    always_comb
    begin
        state_next     = state_reg;
        walk_addr_next = walk_addr_reg;
        walk_left_next = walk_left_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && (q_head.kind == CMD_READ) && (head_count != FW'(1)))
                begin
                    state_next     = BK_WALK;
                    walk_addr_next = head_addr - AW'(1);
                    walk_left_next = head_count - FW'(1);
                end
            end
            BK_WALK:
            begin
                walk_addr_next = walk_addr_reg - AW'(1);
                walk_left_next = walk_left_reg - FW'(1);
                if (walk_left_reg == FW'(1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Issue memory access and result tag
    always_comb
    begin
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = head_addr;
        ram_raddr    = head_addr;
        issue        = 1'b0;
        issue_ram    = 1'b0;
        issue_status = ST_OK;
        issue_last   = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    issue = 1'b1;
                    unique case (q_head.kind)
                        CMD_WRITE:
                        begin
                            ram_we = 1'b1;
                        end
                        CMD_READ:
                        begin
                            ram_re     = 1'b1;
                            issue_ram  = 1'b1;
                            issue_last = (head_count == FW'(1));
                        end
                        CMD_REPORT:
                        begin
                            issue_status = q_head.status;
                        end
                        default:
                        begin
                            issue = 1'b0;
                        end
                    endcase
                end
            end
            BK_WALK:
            begin
                ram_re     = 1'b1;
                ram_raddr  = walk_addr_reg;
                issue      = 1'b1;
                issue_ram  = 1'b1;
                issue_last = (walk_left_reg == FW'(1));
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            p_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= issue;
            done_reg    <= p_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        walk_addr_reg  <= walk_addr_next;
        walk_left_reg  <= walk_left_next;
        p_use_ram_reg  <= issue_ram;
        p_status_reg   <= issue_status;
        p_last_reg     <= issue_last;
        rsp_reg.value  <= p_use_ram_reg ? ram_rdata : '0;
        rsp_reg.status <= p_status_reg;
        rsp_reg.last   <= p_last_reg;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

[tb/partitioned_multi_stack_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partitioned_multi_stack_tb - self-checking bench for the partitioned stacks
// Drives push, pop and display items at the falling edge. It keeps its own
// copy of the shared memory, fill counts and stack count to predict every
// result. Each result seen with done high is checked in order, field by
// field. It covers several stack-count settings and several sender gap rates.
// ----------------------------------------------------------------------------
module partitioned_multi_stack_tb;

    import psk_pkg::*;

    localparam int TOTAL_WORDS = 32;
    localparam int STACKS      = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 16;

    // Track stack contents and the queue of results still owed by the block
    class stack_scoreboard;
        logic [WORD_W-1:0] words [TOTAL_WORDS];
        int unsigned       depth [STACKS];
        logic [2:0]        count_reg;
        rsp_item_t         due [$];
        int                errors;
        int                items;
        int                results;
        int                status_seen [4];

        function new();
            foreach (words[i]) words[i] = '0;
            clear_all(3'd1);
            errors  = 0;
            items   = 0;
            results = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Take a new stack count and empty every stack
        function void clear_all(logic [2:0] setting);
            count_reg = setting;
            foreach (depth[i]) depth[i] = 0;
        endfunction

        function int unsigned active_count();
            int unsigned n;
            n = count_reg;
            if (n < 1) n = 1;
            if (n > STACKS) n = STACKS;
            return n;
        endfunction

        function void owe(logic [WORD_W-1:0] val, logic [1:0] st, logic fin);
            rsp_item_t r;
            r.value  = val;
            r.status = st;
            r.last   = fin;
            due.push_back(r);
        endfunction

        // Apply an accepted item and queue its results; return how many
        function int note_item(req_item_t it);
            int unsigned n;
            int unsigned region;
            int unsigned base;
            int unsigned fill;
            int          before_size;
            before_size = due.size();
            items++;
            n      = active_count();
            region = TOTAL_WORDS / n;
            if (it.stack_index >= n) begin
                owe('0, ST_NOSTACK, 1'b1);
                return 1;
            end
            base = it.stack_index * region;
            fill = depth[it.stack_index];
            case (it.func)
                FUNC_PUSH: begin
                    if (fill >= region) begin
                        owe('0, ST_FULL, 1'b1);
                    end
                    else begin
                        words[(base + fill) % TOTAL_WORDS] = it.push_value;
                        depth[it.stack_index] = fill + 1;
                        owe('0, ST_OK, 1'b1);
                    end
                end
                FUNC_POP: begin
                    if (fill == 0) begin
                        owe('0, ST_EMPTY, 1'b1);
                    end
                    else begin
                        depth[it.stack_index] = fill - 1;
                        owe(words[(base + fill - 1) % TOTAL_WORDS], ST_OK, 1'b1);
                    end
                end
                FUNC_SHOW: begin
                    if (fill == 0) begin
                        owe('0, ST_EMPTY, 1'b1);
                    end
                    else begin
                        // Walk from top to bottom, mark the bottom entry
                        for (int k = 0; k < fill; k++)
                            owe(words[(base + fill - 1 - k) % TOTAL_WORDS], ST_OK,
                                (k + 1 == fill));
                    end
                end
                default: ;
            endcase
            return due.size() - before_size;
        endfunction

        // Compare one result with the oldest one owed
        function void check_result(rsp_item_t got);
            rsp_item_t want;
            results++;
            status_seen[got.status]++;
            if (due.size() == 0) begin
                $error("result with nothing pending: value %0d status %0d last %0d",
                       got.value, got.status, got.last);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, got.value);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    req_item_t              req;
    logic                   cfg_we;
    logic [COUNT_CFG_W-1:0] cfg_data;
    logic                   done;
    rsp_item_t              rsp;

    stack_scoreboard sb;
    int              cycle_count;
    int              settings_used;

    partitioned_multi_stack #(
        .TOTAL_DEPTH (TOTAL_WORDS),
        .MAX_STACKS  (STACKS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .rsp      (rsp)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check every result as it goes past
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(rsp);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic req_item_t make_item(logic [1:0] func, logic [1:0] idx,
                                            logic [WORD_W-1:0] word);
        req_item_t it;
        it.func        = func;
        it.stack_index = idx;
        it.push_value  = word;
        return it;
    endfunction

    // Mostly random words, now and then an extreme
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random operation, mostly on a stack that exists
    function automatic req_item_t random_item(int unsigned n);
        int          pick;
        logic [1:0]  func;
        logic [1:0]  idx;
        pick = $urandom_range(0, 99);
        if (pick < 45)      func = FUNC_PUSH;
        else if (pick < 72) func = FUNC_POP;
        else if (pick < 92) func = FUNC_SHOW;
        else                func = FUNC_NONE;
        if ($urandom_range(0, 99) < 85) idx = 2'($urandom_range(0, n - 1));
        else                            idx = 2'($urandom_range(0, STACKS - 1));
        return make_item(func, idx, rand_word());
    endfunction

    // Present one item and hold it until the block takes it
    task automatic issue(input req_item_t it, output int nres);
        @(negedge clk);
        start <= 1'b1;
        req   <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        nres = sb.note_item(it);
    endtask

    // Now and then, with the given percent chance, leave start low before the next item
    task automatic pace(input int gap_pct);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
            repeat ($urandom_range(1, 3)) begin
                @(negedge clk);
                start <= 1'b0;
            end
    endtask

    // Drop start and hold off until every owed result has arrived
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.due.size() != 0) @(posedge clk);
    endtask

    // Write the stack count once the block has gone quiet
    task automatic reconfigure(input logic [2:0] setting);
        drain();
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= setting;
        @(posedge clk);
        sb.clear_all(setting);
        settings_used++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random phase: push bursts to fill stacks, mixed with random items
    task automatic run_phase(input logic [2:0] setting, input int gap_pct,
                             input int budget);
        int          sent;
        int          nres;
        int          burst;
        int unsigned n;
        logic [1:0]  target;
        reconfigure(setting);
        sent = 0;
        while (sent < budget) begin
            n = sb.active_count();
            if ($urandom_range(0, 99) < 25) begin
                target = 2'($urandom_range(0, n - 1));
                burst  = $urandom_range(1, TOTAL_WORDS / n + 1);
                // Keep the burst inside what is left of the phase
                if (burst > budget - sent)
                    burst = budget - sent;
                repeat (burst) begin
                    pace(gap_pct);
                    issue(make_item(FUNC_PUSH, target, rand_word()), nres);
                    sent++;
                end
            end
            else begin
                if ($urandom_range(0, 99) < 4)
                    drain();
                pace(gap_pct);
                issue(random_item(n), nres);
                if (nres > 0) sent++;
            end
        end
    endtask

    initial
    begin
        int          nres;
        logic [2:0]  phase_setting [8];
        int          phase_gap [4];
        sb            = new();
        cycle_count   = 0;
        settings_used = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        req      = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        phase_setting = '{3'd2, 3'd7, 3'd0, 3'd3, 3'd5, 3'd1, 3'd6, 3'd4};
        // no gaps, heavy gaps, none again (the receiver has no hold-off), light
        phase_gap     = '{0, 53, 0, 24};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: one stack over the whole memory after reset
        issue(make_item(FUNC_POP,  2'd0, 32'h0), nres);
        issue(make_item(FUNC_SHOW, 2'd0, 32'h0), nres);
        issue(make_item(FUNC_PUSH, 2'd0, 32'h7fff_ffff), nres);
        issue(make_item(FUNC_PUSH, 2'd0, 32'h8000_0000), nres);
        issue(make_item(FUNC_PUSH, 2'd0, 32'hffff_ffff), nres);
        issue(make_item(FUNC_PUSH, 2'd0, 32'h0000_0000), nres);
        issue(make_item(FUNC_SHOW, 2'd0, 32'h0), nres);
        issue(make_item(FUNC_POP,  2'd0, 32'h0), nres);
        issue(make_item(FUNC_NONE, 2'd0, 32'h1234_5678), nres);
        issue(make_item(FUNC_PUSH, 2'd1, 32'h5555_aaaa), nres);
        issue(make_item(FUNC_POP,  2'd3, 32'h0), nres);
        issue(make_item(FUNC_NONE, 2'd2, 32'h0), nres);

        // Directed: four stacks, fill the top one past its limit
        reconfigure(3'd4);
        for (int k = 0; k < 9; k++)
            issue(make_item(FUNC_PUSH, 2'd3, 32'ha5a5_0000 + k), nres);
        issue(make_item(FUNC_SHOW, 2'd3, 32'h0), nres);
        issue(make_item(FUNC_POP,  2'd3, 32'h0), nres);
        issue(make_item(FUNC_SHOW, 2'd0, 32'h0), nres);
        issue(make_item(FUNC_POP,  2'd2, 32'h0), nres);

        // Random phases over every setting and gap rate
        for (int p = 0; p < 8; p++)
            run_phase(phase_setting[p], phase_gap[p % 4], 10);

        drain();
        repeat (40) @(posedge clk);

        $display("Covered %0d items and %0d results over %0d stack-count settings.",
                 sb.items, sb.results, settings_used);
        $display("Results by status: ok %0d, full %0d, empty %0d, no stack %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOSTACK]);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
